// ----- hw/rtl/code_length_run_encoder_defines.svh -----
// assertion macros for the code length run encoder
// clk and rst_n are taken from the scope where a macro is used
`ifndef CODE_LENGTH_RUN_ENCODER_DEFINES_SVH
`define CODE_LENGTH_RUN_ENCODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cle_pkg.sv -----
// ---------------------------------------------------------------------------
// cle_pkg
// shared widths, symbol codes and result bundle types of the encoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;

  localparam int LEN_W   = 4;
  localparam int SYM_W   = 5;
  localparam int CNT_W   = 8;
  localparam int MAX_RES = 3;
  localparam int NRES_W  = 2;
  localparam int IDX_W   = 2;

  localparam logic [SYM_W-1:0] SYM_REPEAT     = 5'd16;
  localparam logic [SYM_W-1:0] SYM_ZERO_SHORT = 5'd17;
  localparam logic [SYM_W-1:0] SYM_ZERO_LONG  = 5'd18;

  localparam logic [CNT_W-1:0] ZERO_CHUNK_MAX = 8'd138;
  localparam logic [CNT_W-1:0] REP_CHUNK_MAX  = 8'd6;
  localparam logic [CNT_W-1:0] SHORT_ZERO_MAX = 8'd10;
  localparam logic [CNT_W-1:0] MIN_RUN        = 8'd3;

  // one result item
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } res_t;

  // all results caused by one input item, packed from slot 0
  typedef struct packed {
    logic [NRES_W-1:0]      n;
    res_t [MAX_RES-1:0]     res;
  } bundle_t;

  // queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cle_if.sv -----
// ---------------------------------------------------------------------------
// cle_if
// valid/ready channels for code lengths in and code-length symbols out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface cle_in_if;
  logic                      valid;
  logic                      ready;
  logic [cle_pkg::LEN_W-1:0] length_value;
  logic                      is_last;

  modport source (output valid, output length_value, output is_last, input ready);
  modport sink   (input valid, input length_value, input is_last, output ready);
endinterface

interface cle_out_if;
  logic                      valid;
  logic                      ready;
  logic [cle_pkg::SYM_W-1:0] symbol;
  logic [cle_pkg::CNT_W-1:0] repeat_count;
  logic                      stream_end;

  modport source (output valid, output symbol, output repeat_count, output stream_end,
                  input ready);
  modport sink   (input valid, input symbol, input repeat_count, input stream_end,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/code_length_run_encoder.sv -----
// ---------------------------------------------------------------------------
// code_length_run_encoder
// deflate code-length run-length encoder, code lengths in, symbols out
// ---------------------------------------------------------------------------
// Takes one 4-bit code length per item with a last flag and gives the
// code-length alphabet symbols with the run length each covers: a nonzero
// length goes once as itself, its repeats as 16 in chunks of 3..6 (shorter
// tails as plain copies), zero runs as 18 (11..138), 17 (3..10) or single
// zeros. Full chunks leave as soon as they fill; the final result of a
// sequence carries stream_end and the next item starts afresh. One input
// item is taken every cycle while each item yields at most one result and
// the output is ready; an item with more (up to 3) holds the output longer,
// since the output register passes one result per cycle. A two-bundle
// queue between the run tracker and the output stage absorbs that, so
// the input stays ready until the queue holds two unfinished bundles.
// An accepted item's bundle is written into the queue, and its first result
// is loaded from the queue head into the output register once that register
// is empty or its result is being taken.
`timescale 1ns / 1ps
`default_nettype none
`include "code_length_run_encoder_defines.svh"
module code_length_run_encoder (
  input  logic      clk,
  input  logic      rst_n,
  cle_in_if.sink    in_ch,
  cle_out_if.source out_ch
);

  // front to queue
  logic             push;
  cle_pkg::bundle_t bundle;
  // queue to back
  logic             pop;
  cle_pkg::bundle_t head;
  cle_pkg::q_stat_t q_stat;

  // run tracking, one item per cycle while the queue is not full, empty bundles are dropped here
  cle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .bundle (bundle)
  );

  // decoupling queue
  cle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_bundle (bundle),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // serialiser and output register
  cle_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // a pushed bundle never meets a full queue
  `CLE_ASSERT_IMP(a_no_overflow, push, !q_stat.full, "bundle pushed into full queue")

  // every last item leaves at least one result behind
  `CLE_ASSERT_NXT(a_last_queued, in_ch.valid && in_ch.ready && in_ch.is_last,
                  !q_stat.empty, "last item produced no result")

  // repeat counts match their symbol class
  `CLE_ASSERT_IMP(a_rep_range,
                  out_ch.valid && out_ch.symbol == cle_pkg::SYM_REPEAT,
                  out_ch.repeat_count >= 8'd3 && out_ch.repeat_count <= 8'd6,
                  "repeat symbol count out of range")

  `CLE_ASSERT_IMP(a_zero_range,
                  out_ch.valid && (out_ch.symbol == cle_pkg::SYM_ZERO_SHORT ||
                                   out_ch.symbol == cle_pkg::SYM_ZERO_LONG),
                  out_ch.repeat_count >= 8'd3 && out_ch.repeat_count <= 8'd138,
                  "zero run count out of range")

  `CLE_ASSERT_IMP(a_plain_one, out_ch.valid && out_ch.symbol < cle_pkg::SYM_REPEAT,
                  out_ch.repeat_count == 8'd1, "plain length with count not one")

endmodule
`default_nettype wire

// ----- hw/rtl/cle_front.sv -----
// ---------------------------------------------------------------------------
// cle_front
// tracks the open run and turns each code length into a result bundle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cle_front (
  input  logic             clk,
  input  logic             rst_n,
  cle_in_if.sink           in_ch,
  input  cle_pkg::q_stat_t q_stat,
  output logic             push,
  output cle_pkg::bundle_t bundle
);

  typedef struct packed {
    logic [cle_pkg::NRES_W-1:0] n;
    cle_pkg::res_t              r0;
    cle_pkg::res_t              r1;
  } close_t;

  // results that flush an open run
  function automatic close_t close_fn(input logic active,
                                      input logic [cle_pkg::LEN_W-1:0] val,
                                      input logic [cle_pkg::CNT_W-1:0] p);
    close_t c;
    c = '0;
    if (active) begin
      if (val == '0) begin
        if (p > cle_pkg::SHORT_ZERO_MAX) begin
          c.n  = 2'd1;
          c.r0 = '{sym: cle_pkg::SYM_ZERO_LONG, cnt: p, last: 1'b0};
        end else if (p >= cle_pkg::MIN_RUN) begin
          c.n  = 2'd1;
          c.r0 = '{sym: cle_pkg::SYM_ZERO_SHORT, cnt: p, last: 1'b0};
        end else begin
          c.n  = p[1:0];
          c.r0 = '{sym: '0, cnt: 8'd1, last: 1'b0};
          c.r1 = c.r0;
        end
      end else begin
        if (p >= cle_pkg::MIN_RUN) begin
          c.n  = 2'd1;
          c.r0 = '{sym: cle_pkg::SYM_REPEAT, cnt: p, last: 1'b0};
        end else begin
          c.n  = p[1:0];
          c.r0 = '{sym: {1'b0, val}, cnt: 8'd1, last: 1'b0};
          c.r1 = c.r0;
        end
      end
    end
    return c;
  endfunction

  logic                      run_active_r, run_active_nxt;
  logic [cle_pkg::LEN_W-1:0] run_value_r, run_value_nxt;
  logic [cle_pkg::CNT_W-1:0] pend_r, pend_nxt;
  logic                      accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && (bundle.n != '0);

  always_comb begin
    logic                      same;
    logic [cle_pkg::CNT_W-1:0] p1;
    logic [cle_pkg::NRES_W-1:0] n;
    close_t                    c_old;
    close_t                    c_end;
    same           = run_active_r && (in_ch.length_value == run_value_r);
    p1             = pend_r + 8'd1;
    n              = '0;
    bundle         = '0;
    run_active_nxt = 1'b1;
    run_value_nxt  = in_ch.length_value;
    pend_nxt       = p1;
    c_old          = close_fn(run_active_r, run_value_r, pend_r);
    if (same) begin
      // full chunks leave at once
      if (in_ch.length_value == '0 && p1 >= cle_pkg::ZERO_CHUNK_MAX) begin
        bundle.res[0] = '{sym: cle_pkg::SYM_ZERO_LONG, cnt: cle_pkg::ZERO_CHUNK_MAX,
                          last: 1'b0};
        n        = 2'd1;
        pend_nxt = '0;
      end else if (in_ch.length_value != '0 && p1 >= cle_pkg::REP_CHUNK_MAX) begin
        bundle.res[0] = '{sym: cle_pkg::SYM_REPEAT, cnt: cle_pkg::REP_CHUNK_MAX,
                          last: 1'b0};
        n        = 2'd1;
        pend_nxt = '0;
      end
    end else begin
      // value changed: flush the old run, open a new one
      if (c_old.n > 2'd0) bundle.res[0] = c_old.r0;
      if (c_old.n > 2'd1) bundle.res[1] = c_old.r1;
      n = c_old.n;
      if (in_ch.length_value == '0) begin
        pend_nxt = 8'd1;
      end else begin
        bundle.res[n] = '{sym: {1'b0, in_ch.length_value}, cnt: 8'd1, last: 1'b0};
        n        = n + 2'd1;
        pend_nxt = '0;
      end
    end
    c_end = close_fn(1'b1, run_value_nxt, pend_nxt);
    if (in_ch.is_last) begin
      if (c_end.n > 2'd0) bundle.res[n] = c_end.r0;
      if (c_end.n > 2'd1) bundle.res[n + 2'd1] = c_end.r1;
      n = n + c_end.n;
      if (n != '0) bundle.res[n - 2'd1].last = 1'b1;
      run_active_nxt = 1'b0;
      run_value_nxt  = '0;
      pend_nxt       = '0;
    end
    bundle.n = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      run_value_r  <= '0;
      pend_r       <= '0;
    end else if (accept) begin
      run_active_r <= run_active_nxt;
      run_value_r  <= run_value_nxt;
      pend_r       <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cle_queue.sv -----
// ---------------------------------------------------------------------------
// cle_queue
// two-entry queue of result bundles between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cle_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cle_pkg::bundle_t wr_bundle,
  input  logic             pop,
  output cle_pkg::bundle_t head,
  output cle_pkg::q_stat_t q_stat
);

  cle_pkg::bundle_t mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push, do_pop;

  assign q_stat.empty = (count_r == 2'd0);
  assign q_stat.full  = (count_r == 2'd2);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cle_back.sv -----
// ---------------------------------------------------------------------------
// cle_back
// walks the head bundle one result per cycle, while out_ch is ready, into the output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cle_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cle_pkg::bundle_t head,
  input  cle_pkg::q_stat_t q_stat,
  output logic             pop,
  cle_out_if.source        out_ch
);

  logic [cle_pkg::IDX_W-1:0] idx_r;
  logic                      out_valid_r;
  cle_pkg::res_t             out_r;
  logic                      load, at_end;

  assign load   = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign at_end = (idx_r == head.n - 2'd1);
  assign pop    = load && at_end;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.symbol       = out_r.sym;
  assign out_ch.repeat_count = out_r.cnt;
  assign out_ch.stream_end   = out_r.last;

  always_ff @(posedge clk) begin
    if (load) out_r <= head.res[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= at_end ? '0 : idx_r + 2'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_code_length_run_encoder.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_code_length_run_encoder
// self-checking bench for the code-length run encoder
// ---------------------------------------------------------------------------
// A short directed set of streams comes first, then a full zero chunk, then
// random streams of runs mixed with loose noise items. A predictor inside
// the bench tracks the open run and builds the expected symbols for every
// accepted item. The monitor checks every result against the oldest one.
// The sender works in bursts with gaps. The receiver stalls in changing
// patterns, and once it holds off for a long stretch so that the input
// side backs up.
// ---------------------------------------------------------------------------
module tb_code_length_run_encoder;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 56;
  localparam int HOLD_AFTER   = 170;     // accepted items before the long hold-off
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int RUN_LIMIT_NS = 2_000_000;

  localparam logic [cle_pkg::CNT_W-1:0] PLAIN_COUNT = 8'd1;

  // one code length as offered on the input channel
  typedef struct packed {
    logic [cle_pkg::LEN_W-1:0] length;
    logic                      tail;
  } code_item_t;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;

  cle_in_if  in_ch();
  cle_out_if out_ch();

  code_length_run_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  code_item_t    pending_items[$];     // items still to be offered
  cle_pkg::res_t expected_symbols[$];  // predicted symbols, oldest first

  int total_items    = 0;
  int items_accepted = 0;
  int error_count    = 0;
  int step_results   = 0;
  bit in_fire        = 1'b0;        // input item taken at the last rising edge
  bit hold_off       = 1'b0;

  // predictor copy of the run tracker
  bit                        run_open    = 1'b0;
  logic [cle_pkg::LEN_W-1:0] run_len     = '0;
  logic [cle_pkg::CNT_W-1:0] run_pending = '0;

  // sender burst shaping
  int burst_left = 0;
  int gap_left   = 0;

  // receiver pattern state
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_tick      = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // predictor
  // -------------------------------------------------------------------------

  function automatic void push_symbol(logic [cle_pkg::SYM_W-1:0] sym,
                                      logic [cle_pkg::CNT_W-1:0] cnt);
    cle_pkg::res_t r;
    r.sym  = sym;
    r.cnt  = cnt;
    r.last = 1'b0;
    expected_symbols.push_back(r);
    step_results++;
  endfunction

  // flush whatever the open run still owes, then forget the run
  function automatic void close_open_run();
    if (run_open) begin
      if (run_len == '0) begin
        // zero runs: long form above ten, short form from three, else singles
        if (run_pending > cle_pkg::SHORT_ZERO_MAX)
          push_symbol(cle_pkg::SYM_ZERO_LONG, run_pending);
        else if (run_pending >= cle_pkg::MIN_RUN)
          push_symbol(cle_pkg::SYM_ZERO_SHORT, run_pending);
        else
          repeat (run_pending) push_symbol({1'b0, run_len}, PLAIN_COUNT);
      end else if (run_pending >= cle_pkg::MIN_RUN) begin
        push_symbol(cle_pkg::SYM_REPEAT, run_pending);
      end else begin
        // short tail of repeats goes as plain copies
        repeat (run_pending) push_symbol({1'b0, run_len}, PLAIN_COUNT);
      end
    end
    run_open    = 1'b0;
    run_len     = '0;
    run_pending = '0;
  endfunction

  function automatic void predict_code_length(code_item_t item);
    cle_pkg::res_t tail_res;
    step_results = 0;
    if (run_open && item.length == run_len) begin
      run_pending = run_pending + 1'b1;
      // a full chunk leaves at once and the count restarts within the run
      if (item.length == '0 && run_pending >= cle_pkg::ZERO_CHUNK_MAX) begin
        push_symbol(cle_pkg::SYM_ZERO_LONG, cle_pkg::ZERO_CHUNK_MAX);
        run_pending = '0;
      end else if (item.length != '0 && run_pending >= cle_pkg::REP_CHUNK_MAX) begin
        push_symbol(cle_pkg::SYM_REPEAT, cle_pkg::REP_CHUNK_MAX);
        run_pending = '0;
      end
    end else begin
      close_open_run();
      run_open = 1'b1;
      run_len  = item.length;
      if (item.length == '0) begin
        run_pending = 8'd1;
      end else begin
        // a nonzero length is sent once straight away
        push_symbol({1'b0, item.length}, PLAIN_COUNT);
        run_pending = '0;
      end
    end
    if (item.tail) begin
      // end of stream: flush and flag the final symbol of this item
      close_open_run();
      if (step_results > 0) begin
        tail_res      = expected_symbols.pop_back();
        tail_res.last = 1'b1;
        expected_symbols.push_back(tail_res);
      end
    end
  endfunction

  // -------------------------------------------------------------------------
  // stimulus building
  // -------------------------------------------------------------------------

  function automatic void add_run(logic [cle_pkg::LEN_W-1:0] len, int count, bit close);
    code_item_t item;
    for (int i = 0; i < count; i++) begin
      item.length = len;
      item.tail   = close && (i == count - 1);
      pending_items.push_back(item);
    end
  endfunction

  // well-formed stream: a few runs, the last item closes the stream
  function automatic void add_random_stream();
    int                        runs;
    int                        count;
    logic [cle_pkg::LEN_W-1:0] len;
    runs = $urandom_range(1, 8);
    for (int r = 0; r < runs; r++) begin
      if ($urandom_range(0, 9) < 4)
        len = '0;
      else
        len = cle_pkg::LEN_W'($urandom_range(1, 15));
      case ($urandom_range(0, 19))
        0, 1:       count = $urandom_range(11, 60);
        2, 3, 4, 5: count = $urandom_range(5, 20);
        default:    count = $urandom_range(1, 4);
      endcase
      add_run(len, count, r == runs - 1);
    end
  endfunction

  // loose items with random values and random stream ends
  function automatic void add_noise();
    code_item_t item;
    repeat ($urandom_range(1, 6)) begin
      item.length = cle_pkg::LEN_W'($urandom_range(0, 15));
      item.tail   = ($urandom_range(0, 3) == 0);
      pending_items.push_back(item);
    end
  endfunction

  // -------------------------------------------------------------------------
  // sender: bursts of random length with random gaps, some gaps empty so
  // that bursts run together into long unbroken stretches
  // -------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    code_item_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        item = pending_items.pop_front();
        in_ch.length_value <= item.length;
        in_ch.is_last      <= item.tail;
        in_ch.valid        <= 1'b1;
        if (burst_left > 0)
          burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // receiver: switches between randomly chosen stall patterns, and
  // is forced low while the long hold-off is in force
  // -------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(30, 120);
    end
    rx_mode_left--;
    rx_tick++;
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ch.ready <= (rx_tick % 4 != 0);
        default:     out_ch.ready <= ($urandom_range(0, 9) < 4);
      endcase
    end
  end

  // long hold-off on the output while the sender keeps offering, so the
  // bundle queue fills and the input has to stall
  initial begin : output_hold_off
    wait (items_accepted >= HOLD_AFTER);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // -------------------------------------------------------------------------
  // monitor: predicts on every accepted input item, then checks any result
  // taken on the same edge against the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    code_item_t    seen;
    cle_pkg::res_t got;
    cle_pkg::res_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_fire     = 1'b1;
        seen.length = in_ch.length_value;
        seen.tail   = in_ch.is_last;
        items_accepted++;
        predict_code_length(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.sym  = out_ch.symbol;
        got.cnt  = out_ch.repeat_count;
        got.last = out_ch.stream_end;
        if (expected_symbols.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result sym %0d count %0d end %0b",
                     $time, got.sym, got.cnt, got.last);
        end else begin
          want = expected_symbols.pop_front();
          if (got.sym !== want.sym || got.cnt !== want.cnt || got.last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: expected sym %0d count %0d end %0b, got sym %0d count %0d end %0b",
                       $time, want.sym, want.cnt, want.last, got.sym, got.cnt, got.last);
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin : main
    int random_start;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.length_value = '0;
    in_ch.is_last      = 1'b0;
    out_ch.ready       = 1'b0;

    // directed streams
    add_run(4'd15, 1, 1'b1);   // largest length alone, ends the stream
    add_run(4'd0, 1, 1'b1);    // lone zero at stream end
    add_run(4'd0, 2, 1'b1);    // two zeros go as singles
    add_run(4'd0, 3, 1'b0);    // short zero run closed by a value change
    add_run(4'd1, 1, 1'b1);
    add_run(4'd3, 3, 1'b1);    // two repeats go as plain copies
    add_run(4'd9, 7, 1'b1);    // full repeat chunk, nothing left to flush
    add_run(4'd8, 4, 1'b0);    // three repeats as a short repeat symbol
    add_run(4'd0, 1, 1'b1);

    // full zero chunk, then one zero left over inside the same run
    add_run(4'd0, 139, 1'b0);
    add_run(4'd7, 1, 1'b1);

    // random part, mostly well-formed streams with some loose noise
    random_start = pending_items.size();
    while (pending_items.size() - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        add_noise();
      else
        add_random_stream();
    end
    // cut the random part to size, the closing item below ends any open stream
    while (pending_items.size() > random_start + RANDOM_ITEMS)
      void'(pending_items.pop_back());
    // close whatever stream the noise may have left open
    add_run(cle_pkg::LEN_W'($urandom_range(0, 15)), 1, 1'b1);
    total_items = pending_items.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_accepted < total_items) @(posedge clk);
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
